### rtl/fbv_pkg.sv
package fbv_pkg;

    localparam int PLANE_COUNT = 4;
    localparam int POINT_COUNT = 5;
    localparam int CFG_PLANES  = 4;
    localparam int MAX_POINTS  = 9;

    // Planes without a register count as satisfied, so only these are evaluated.
    localparam int ACT_PLANES = (PLANE_COUNT < CFG_PLANES) ? PLANE_COUNT : CFG_PLANES;
    localparam int NPTS       = (POINT_COUNT < MAX_POINTS) ? POINT_COUNT : MAX_POINTS;

    localparam int COORD_W  = 24;
    localparam int HALF_W   = 23;
    localparam int PT_W     = COORD_W + 1;
    localparam int NRM_W    = 16;
    localparam int OFF_W    = 32;
    localparam int PROD_W   = PT_W + NRM_W;
    localparam int OFF_SH   = 14;
    localparam int DIST_W   = OFF_W + OFF_SH + 1;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CAM_W    = 2 * COORD_W;
    localparam int REASON_W = 2;

    // Each test point picks one of three x values and one of three z values.
    localparam int NSEL  = 3;
    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] SEL_PLUS  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_MINUS = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MID   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAMERA = 3'd4;

    localparam logic [REASON_W-1:0] REASON_NONE   = 2'd0;
    localparam logic [REASON_W-1:0] REASON_POINT  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_CAMERA = 2'd2;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] nz;
        logic signed [OFF_W-1:0] off;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cz;
        logic        [HALF_W-1:0]  hw;
        logic        [HALF_W-1:0]  hd;
    } t_box;

    typedef struct packed {
        logic                       valid;
        logic [NSEL-1:0][PT_W-1:0]  x;
        logic [NSEL-1:0][PT_W-1:0]  z;
    } t_pts;

    typedef struct packed {
        logic            valid;
        logic [NPTS-1:0] pt_in;
        logic            cam_in;
    } t_hits;

    // Point order: four corners, the center, then the edge midpoints.
    function automatic logic [SEL_W-1:0] pt_xsel(input int k);
        logic [SEL_W-1:0] s;
        case (k)
            0, 2, 5: s = SEL_PLUS;
            1, 3, 6: s = SEL_MINUS;
            default: s = SEL_MID;
        endcase
        return s;
    endfunction

    function automatic logic [SEL_W-1:0] pt_zsel(input int k);
        logic [SEL_W-1:0] s;
        case (k)
            0, 1, 7: s = SEL_PLUS;
            2, 3, 8: s = SEL_MINUS;
            default: s = SEL_MID;
        endcase
        return s;
    endfunction

endpackage

### rtl/fbv_box_if.sv
interface fbv_box_if import fbv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_center_x;
    logic signed [COORD_W-1:0] box_center_z;
    logic        [HALF_W-1:0]  box_half_width;
    logic        [HALF_W-1:0]  box_half_depth;

    modport source (
        output valid, box_center_x, box_center_z, box_half_width, box_half_depth,
        input  ready
    );
    modport sink (
        input  valid, box_center_x, box_center_z, box_half_width, box_half_depth,
        output ready
    );
endinterface

### rtl/fbv_vis_if.sv
interface fbv_vis_if import fbv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                visible;
    logic [REASON_W-1:0] visible_reason;

    modport source (
        output valid, visible, visible_reason,
        input  ready
    );
    modport sink (
        input  valid, visible, visible_reason,
        output ready
    );
endinterface

### rtl/fbv_point_stage.sv
module fbv_point_stage import fbv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_valid,
    input  t_box i_box,
    output t_pts o_pts
);

    logic                      r_v1;
    t_box                      r_box;
    logic                      r_v2;
    logic [NSEL-1:0][PT_W-1:0] r_x;
    logic [NSEL-1:0][PT_W-1:0] r_z;
    logic [NSEL-1:0][PT_W-1:0] n_x;
    logic [NSEL-1:0][PT_W-1:0] n_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_box <= i_box;
            r_x   <= n_x;
            r_z   <= n_z;
        end
    end

    // Corner coordinates need one extra bit so that nothing wraps.
    always_comb begin
        logic [PT_W-1:0] cx;
        logic [PT_W-1:0] cz;
        logic [PT_W-1:0] hw;
        logic [PT_W-1:0] hd;
        cx = {r_box.cx[COORD_W-1], r_box.cx};
        cz = {r_box.cz[COORD_W-1], r_box.cz};
        hw = {2'b00, r_box.hw};
        hd = {2'b00, r_box.hd};
        n_x[SEL_PLUS]  = cx + hw;
        n_x[SEL_MINUS] = cx - hw;
        n_x[SEL_MID]   = cx;
        n_z[SEL_PLUS]  = cz + hd;
        n_z[SEL_MINUS] = cz - hd;
        n_z[SEL_MID]   = cz;
    end

    always_comb begin
        o_pts.valid = r_v2;
        o_pts.x     = r_x;
        o_pts.z     = r_z;
    end

endmodule

### rtl/fbv_dot_stage.sv
module fbv_dot_stage import fbv_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  t_pts                       i_pts,
    input  t_plane [CFG_PLANES-1:0]    i_planes,
    input  logic signed [COORD_W-1:0]  i_cam_x,
    input  logic signed [COORD_W-1:0]  i_cam_z,
    output t_hits                      o_hits
);

    logic                     r_v3;
    logic signed [PROD_W-1:0] r_px [NSEL][ACT_PLANES];
    logic signed [PROD_W-1:0] r_pz [NSEL][ACT_PLANES];
    logic signed [PROD_W-1:0] n_px [NSEL][ACT_PLANES];
    logic signed [PROD_W-1:0] n_pz [NSEL][ACT_PLANES];
    logic                     r_cx_in;
    logic                     r_cz_in;
    logic                     n_cx_in;
    logic                     n_cz_in;
    logic                     r_v4;
    logic [NPTS-1:0]          r_pt_in;
    logic [NPTS-1:0]          n_pt_in;
    logic                     r_cam_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v3 <= i_pts.valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px     <= n_px;
            r_pz     <= n_pz;
            r_cx_in  <= n_cx_in;
            r_cz_in  <= n_cz_in;
            r_pt_in  <= n_pt_in;
            r_cam_in <= r_cx_in && r_cz_in;
        end
    end

    // Only three distinct x and z values exist, so products are shared by points.
    always_comb begin
        for (int i = 0; i < NSEL; i++) begin
            for (int j = 0; j < ACT_PLANES; j++) begin
                n_px[i][j] = $signed(i_pts.x[i]) * i_planes[j].nx;
                n_pz[i][j] = $signed(i_pts.z[i]) * i_planes[j].nz;
            end
        end
    end

    always_comb begin
        logic signed [PT_W-1:0] camx;
        logic signed [PT_W-1:0] camz;
        camx = PT_W'(i_cam_x);
        camz = PT_W'(i_cam_z);
        n_cx_in = (camx < $signed(i_pts.x[SEL_PLUS])) && (camx > $signed(i_pts.x[SEL_MINUS]));
        n_cz_in = (camz < $signed(i_pts.z[SEL_PLUS])) && (camz > $signed(i_pts.z[SEL_MINUS]));
    end

    // A point is inside a plane when its signed distance is negative.
    always_comb begin
        logic signed [DIST_W-1:0] d;
        logic                     all_in;
        for (int k = 0; k < NPTS; k++) begin
            all_in = 1'b1;
            for (int j = 0; j < ACT_PLANES; j++) begin
                d = DIST_W'(r_px[pt_xsel(k)][j]) + DIST_W'(r_pz[pt_zsel(k)][j])
                    - (DIST_W'(i_planes[j].off) <<< OFF_SH);
                all_in = all_in && d[DIST_W-1];
            end
            n_pt_in[k] = all_in;
        end
    end

    always_comb begin
        o_hits.valid  = r_v4;
        o_hits.pt_in  = r_pt_in;
        o_hits.cam_in = r_cam_in;
    end

endmodule

### rtl/fbv_vote_stage.sv
module fbv_vote_stage import fbv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_hits               i_hits,
    output logic                o_valid,
    output logic                o_visible,
    output logic [REASON_W-1:0] o_reason
);

    logic                r_v5;
    logic                r_visible;
    logic [REASON_W-1:0] r_reason;
    logic [REASON_W-1:0] n_reason;

    always_comb begin
        if (|i_hits.pt_in) begin
            n_reason = REASON_POINT;
        end else if (i_hits.cam_in) begin
            n_reason = REASON_CAMERA;
        end else begin
            n_reason = REASON_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_adv) begin
            r_v5 <= i_hits.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_reason  <= n_reason;
            r_visible <= (n_reason != REASON_NONE);
        end
    end

    assign o_valid   = r_v5;
    assign o_visible = r_visible;
    assign o_reason  = r_reason;

endmodule

### rtl/frustum_box_visibility_test.sv
// A request passes five register stages, two in the point stage, two in the dot
// stage and one in the vote stage, before its result appears at the output.
// Throughput: one box per cycle; the five-stage pipeline halts as a whole
// only while a finished result waits at the output register.
// Reset (synchronous, active low) clears all valid bits, both plane and
// camera registers, and drops every request in flight.
module frustum_box_visibility_test import fbv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fbv_box_if.sink              i_box,
    fbv_vis_if.source            o_vis,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_plane [CFG_PLANES-1:0] r_plane;
    logic [CAM_W-1:0]        r_cam;
    logic                    adv;
    t_box                    box;
    t_pts                    pts;
    t_hits                   hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_cam   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_FAR:    r_plane[0] <= t_plane'(i_cfg_data);
                CFG_IDX_NEAR:   r_plane[1] <= t_plane'(i_cfg_data);
                CFG_IDX_RIGHT:  r_plane[2] <= t_plane'(i_cfg_data);
                CFG_IDX_LEFT:   r_plane[3] <= t_plane'(i_cfg_data);
                CFG_IDX_CAMERA: r_cam      <= i_cfg_data[CAM_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv         = !o_vis.valid || o_vis.ready;
    assign i_box.ready = adv;

    always_comb begin
        box.cx = i_box.box_center_x;
        box.cz = i_box.box_center_z;
        box.hw = i_box.box_half_width;
        box.hd = i_box.box_half_depth;
    end

    fbv_point_stage u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_box.valid),
        .i_box   (box),
        .o_pts   (pts)
    );

    fbv_dot_stage u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_pts    (pts),
        .i_planes (r_plane),
        .i_cam_x  (r_cam[CAM_W-1:COORD_W]),
        .i_cam_z  (r_cam[COORD_W-1:0]),
        .o_hits   (hits)
    );

    fbv_vote_stage u_vote (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_hits    (hits),
        .o_valid   (o_vis.valid),
        .o_visible (o_vis.visible),
        .o_reason  (o_vis.visible_reason)
    );

endmodule

### rtl/fbv_checker.sv
module fbv_checker import fbv_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_visible,
    input logic [REASON_W-1:0] i_reason
);

    // The visible flag must agree with the reason code.
    a_flag_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_visible == (i_reason != REASON_NONE)))
        else $error("visible flag disagrees with reason");

    // A stalled result holds its payload.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_visible) && $stable(i_reason))
        else $error("stalled result changed");

    // With an empty output register the block always takes new requests.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // Reset flushes the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind frustum_box_visibility_test fbv_checker u_fbv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_vis.valid),
    .i_out_ready (o_vis.ready),
    .i_visible   (o_vis.visible),
    .i_reason    (o_vis.visible_reason)
);

### dv/frustum_box_visibility_test_tb.sv
module frustum_box_visibility_test_tb;
    import fbv_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 155;
    localparam int MAX_PRINTS   = 200;
    localparam int NORMAL_ONE   = 1 << OFF_SH;

    typedef struct packed {
        logic                visible;
        logic [REASON_W-1:0] reason;
    } t_vis_result;

    class vis_scoreboard;
        logic [CFG_W-1:0] plane_reg[CFG_PLANES];
        logic [CAM_W-1:0] camera_reg;
        t_vis_result      expected_q[$];
        int               mismatches;
        int               results_seen;

        function new();
            foreach (plane_reg[j])
                plane_reg[j] = '0;
            camera_reg   = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx < CFG_PLANES)
                plane_reg[idx] = data;
            else if (idx == CFG_IDX_CAMERA)
                camera_reg = data[CAM_W-1:0];
        endfunction

        function logic [REASON_W-1:0] visibility_reason(t_box b);
            longint              cx, cz, hw, hd, camx, camz, px, pz, plane_dist;
            int                  npts, nplanes, k, j;
            bit                  all_in;
            t_plane              pl;
            logic [REASON_W-1:0] r;
            cx      = longint'($signed(b.cx));
            cz      = longint'($signed(b.cz));
            hw      = longint'(b.hw);
            hd      = longint'(b.hd);
            camx    = longint'($signed(camera_reg[CAM_W-1:COORD_W]));
            camz    = longint'($signed(camera_reg[COORD_W-1:0]));
            npts    = (POINT_COUNT > MAX_POINTS) ? MAX_POINTS : POINT_COUNT;
            nplanes = (PLANE_COUNT > CFG_PLANES) ? CFG_PLANES : PLANE_COUNT;
            r       = REASON_NONE;
            for (k = 0; k < npts; k++) begin
                case (k)
                    0: begin px = cx + hw; pz = cz + hd; end
                    1: begin px = cx - hw; pz = cz + hd; end
                    2: begin px = cx + hw; pz = cz - hd; end
                    3: begin px = cx - hw; pz = cz - hd; end
                    4: begin px = cx;      pz = cz;      end
                    5: begin px = cx + hw; pz = cz;      end
                    6: begin px = cx - hw; pz = cz;      end
                    7: begin px = cx;      pz = cz + hd; end
                    default: begin px = cx; pz = cz - hd; end
                endcase
                all_in = 1'b1;
                // Planes without a register are satisfied by definition.
                for (j = 0; j < nplanes; j++) begin
                    pl         = t_plane'(plane_reg[j]);
                    plane_dist = px * longint'($signed(pl.nx))
                                 + pz * longint'($signed(pl.nz))
                                 - (longint'($signed(pl.off)) <<< OFF_SH);
                    if (plane_dist >= 0)
                        all_in = 1'b0;
                end
                if (all_in && r == REASON_NONE)
                    r = REASON_POINT;
            end
            if (r == REASON_NONE && camx < cx + hw && camx > cx - hw &&
                camz < cz + hd && camz > cz - hd)
                r = REASON_CAMERA;
            return r;
        endfunction

        function void note_request(t_box b);
            t_vis_result e;
            e.reason  = visibility_reason(b);
            e.visible = (e.reason != REASON_NONE);
            expected_q.insert(expected_q.size(), e);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTS)
                $display("mismatch at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task check_result(logic vis, logic [REASON_W-1:0] reason);
            t_vis_result e;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (vis !== e.visible)
                report_mismatch($sformatf("visible %b, expected %b", vis, e.visible));
            if (reason !== e.reason)
                report_mismatch($sformatf("visible_reason %0d, expected %0d", reason, e.reason));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    fbv_box_if box_if();
    fbv_vis_if vis_if();

    vis_scoreboard sb = new();

    int stall_pct   = 0;
    int max_gap     = 0;
    int max_burst   = 1;
    int burst_left  = 0;
    int region_x    = 0;
    int region_z    = 0;
    int region_size = 1024;
    int cam_x       = 0;
    int cam_z       = 0;
    int cycles      = 0;

    frustum_box_visibility_test DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_box      (box_if),
        .o_vis      (vis_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("frustum_box_visibility_test_tb: FAIL");
        $finish;
    end

    // Receiver: stalls come in short runs whose frequency is set per phase.
    initial begin
        int stall_left;
        stall_left = 0;
        vis_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && vis_if.valid && vis_if.ready)
                sb.check_result(vis_if.visible, vis_if.visible_reason);
            if (stall_left > 0) begin
                stall_left--;
                vis_if.ready <= 1'b0;
            end else if (int'($urandom_range(0, 99)) < stall_pct) begin
                stall_left = $urandom_range(0, 4);
                vis_if.ready <= 1'b0;
            end else begin
                vis_if.ready <= 1'b1;
            end
        end
    end

    function automatic int spread(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'h000001;
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] extreme_half();
        case ($urandom_range(0, 3))
            0: return 23'h7FFFFF;
            1: return 23'h000000;
            2: return 23'h000001;
            default: return 23'h400000;
        endcase
    endfunction

    function automatic t_box mk_box(int cx, int cz, int hw, int hd);
        t_box b;
        b.cx = COORD_W'(cx);
        b.cz = COORD_W'(cz);
        b.hw = HALF_W'(hw);
        b.hd = HALF_W'(hd);
        return b;
    endfunction

    function automatic logic [CFG_W-1:0] plane_word(int nx, int nz, longint off);
        return {16'(nx), 16'(nz), 32'(off)};
    endfunction

    // Most boxes land around the region that the planes enclose, some around the
    // camera, the rest anywhere or on the field limits.
    function automatic t_box random_box();
        t_box b;
        int   m;
        m = $urandom_range(0, 99);
        if (m < 55) begin
            b.cx = COORD_W'(region_x + spread(3 * region_size));
            b.cz = COORD_W'(region_z + spread(3 * region_size));
            b.hw = ($urandom_range(0, 9) == 0) ? '0 : HALF_W'($urandom_range(0, region_size));
            b.hd = ($urandom_range(0, 9) == 0) ? '0 : HALF_W'($urandom_range(0, region_size));
        end else if (m < 70) begin
            b.cx = COORD_W'(cam_x + spread(2048));
            b.cz = COORD_W'(cam_z + spread(2048));
            b.hw = HALF_W'($urandom_range(0, 4096));
            b.hd = HALF_W'($urandom_range(0, 4096));
        end else if (m < 90) begin
            b.cx = COORD_W'($urandom);
            b.cz = COORD_W'($urandom);
            b.hw = HALF_W'($urandom);
            b.hd = HALF_W'($urandom);
        end else begin
            b.cx = extreme_coord();
            b.cz = extreme_coord();
            b.hw = extreme_half();
            b.hd = extreme_half();
        end
        return b;
    endfunction

    task automatic send_box(input t_box b);
        int gap;
        if (burst_left == 0) begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                box_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, max_burst);
        end
        burst_left--;
        box_if.valid          <= 1'b1;
        box_if.box_center_x   <= b.cx;
        box_if.box_center_z   <= b.cz;
        box_if.box_half_width <= b.hw;
        box_if.box_half_depth <= b.hd;
        @(posedge i_clk);
        while (!box_if.ready)
            @(posedge i_clk);
        sb.note_request(b);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Also writes the unused indexes with noise, which the block must ignore.
    task automatic load_config(input logic [CFG_W-1:0] far_w, near_w, right_w, left_w,
                               input logic [CFG_W-1:0] cam_w);
        int i;
        wait_idle();
        write_reg(CFG_IDX_FAR, far_w);
        write_reg(CFG_IDX_NEAR, near_w);
        write_reg(CFG_IDX_RIGHT, right_w);
        write_reg(CFG_IDX_LEFT, left_w);
        for (i = int'(CFG_IDX_CAMERA) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        write_reg(CFG_IDX_CAMERA, cam_w);
        cfg_we <= 1'b0;
    endtask

    task automatic random_frustum();
        logic [CFG_W-1:0] w[CFG_PLANES];
        int               nx, nz, j;
        longint           off;
        bit               axis;
        region_x    = spread(1 << 20);
        region_z    = spread(1 << 20);
        region_size = $urandom_range(256, 1 << 18);
        axis        = ($urandom_range(0, 2) == 0);
        for (j = 0; j < CFG_PLANES; j++) begin
            if (axis) begin
                case (CFG_IDX_W'(j))
                    CFG_IDX_FAR:   begin nx = 0;           nz = NORMAL_ONE;  end
                    CFG_IDX_NEAR:  begin nx = 0;           nz = -NORMAL_ONE; end
                    CFG_IDX_RIGHT: begin nx = NORMAL_ONE;  nz = 0;           end
                    default:       begin nx = -NORMAL_ONE; nz = 0;           end
                endcase
            end else begin
                nx = spread(NORMAL_ONE);
                nz = spread(NORMAL_ONE);
            end
            // Pushing each plane out past the region center keeps that center inside.
            off = ((longint'(nx) * region_x + longint'(nz) * region_z) >>> OFF_SH)
                  + $urandom_range(1, region_size);
            w[j] = plane_word(nx, nz, off);
        end
        if ($urandom_range(0, 1) == 0) begin
            cam_x = region_x + spread(region_size);
            cam_z = region_z + spread(region_size);
        end else begin
            cam_x = spread((1 << 23) - 1);
            cam_z = spread((1 << 23) - 1);
        end
        load_config(w[0], w[1], w[2], w[3], {16'($urandom), 24'(cam_x), 24'(cam_z)});
    endtask

    task automatic run_phase(input int stall, gap, burst);
        stall_pct  = stall;
        max_gap    = gap;
        max_burst  = burst;
        burst_left = 0;
        repeat (PHASE_ITEMS) send_box(random_box());
        box_if.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        box_if.valid          <= 1'b0;
        box_if.box_center_x   <= '0;
        box_if.box_center_z   <= '0;
        box_if.box_half_width <= '0;
        box_if.box_half_depth <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers straight out of reset: no point passes a zero plane, and the
        // camera sits at the origin.
        stall_pct = 20;
        max_gap   = 3;
        max_burst = 4;
        send_box(mk_box(0, 0, 0, 0));
        send_box(mk_box(0, 0, 1, 1));
        send_box(mk_box(0, 0, 1, 0));
        send_box(mk_box(-8388608, 8388607, 8388607, 8388607));
        send_box(mk_box(8388607, -8388608, 8388607, 8388607));
        send_box(mk_box(1, 1, 8388607, 8388607));
        box_if.valid <= 1'b0;

        // A square region of half size 1000 around the origin, camera off to the side.
        load_config(plane_word(0, NORMAL_ONE, 1000), plane_word(0, -NORMAL_ONE, 1000),
                    plane_word(NORMAL_ONE, 0, 1000), plane_word(-NORMAL_ONE, 0, 1000),
                    {16'h0000, 24'(5000), 24'(5000)});
        send_box(mk_box(0, 0, 0, 0));
        send_box(mk_box(1000, 0, 0, 0));
        send_box(mk_box(999, 999, 0, 0));
        send_box(mk_box(5000, 5000, 10, 10));
        send_box(mk_box(3000, 0, 2500, 10));
        send_box(mk_box(2000, 2000, 1500, 1500));
        send_box(mk_box(5000, 5000, 5000, 5000));
        send_box(mk_box(0, 0, 3000, 3000));
        send_box(mk_box(0, 5000, 0, 4500));
        send_box(mk_box(5000, 5000, 0, 10));
        send_box(mk_box(-8388608, -8388608, 8388607, 8388607));
        send_box(mk_box(8388607, 8388607, 8388607, 0));
        send_box(mk_box(-1, -1, 1, 1));
        box_if.valid <= 1'b0;

        random_frustum();
        run_phase(0, 0, 1);
        random_frustum();
        run_phase(30, 4, 16);

        // Smallest normals and offset -1 on every plane: inside where x + z is large.
        region_x    = 1 << 16;
        region_z    = 1 << 16;
        region_size = 1 << 15;
        cam_x       = -1;
        cam_z       = -1;
        load_config('1, '1, '1, '1, '1);
        run_phase(20, 3, 8);

        // Largest positive words: every point is inside.
        cam_x = 8388607;
        cam_z = -8388608;
        load_config({16'h7FFF, 16'h7FFF, 32'h7FFFFFFF}, {16'h7FFF, 16'h7FFF, 32'h7FFFFFFF},
                    {16'h7FFF, 16'h7FFF, 32'h7FFFFFFF}, {16'h7FFF, 16'h7FFF, 32'h7FFFFFFF},
                    {16'h0000, 24'h7FFFFF, 24'h800000});
        run_phase(50, 6, 4);

        // Most negative words: no point is inside, only the camera test can pass.
        cam_x = -8388608;
        cam_z = 8388607;
        load_config({16'h8000, 16'h8000, 32'h80000000}, {16'h8000, 16'h8000, 32'h80000000},
                    {16'h8000, 16'h8000, 32'h80000000}, {16'h8000, 16'h8000, 32'h80000000},
                    {16'hFFFF, 24'h800000, 24'h7FFFFF});
        run_phase(10, 2, 30);

        // Two opposed extreme normals leave a thin wedge along x = z; the other two
        // planes have zero normals with a positive offset and always pass.
        region_x    = 1 << 18;
        region_z    = 1 << 18;
        region_size = 1 << 12;
        cam_x       = region_x;
        cam_z       = region_z + 100;
        load_config(plane_word(-32768, 32767, 0), plane_word(32767, -32768, 0),
                    plane_word(0, 0, 1), plane_word(0, 0, 1),
                    {16'h0000, 24'(cam_x), 24'(cam_z)});
        run_phase(70, 8, 6);

        random_frustum();
        run_phase(40, 5, 10);
        random_frustum();
        run_phase(0, 1, 3);

        wait_idle();
        if (sb.mismatches == 0)
            $display("frustum_box_visibility_test_tb: PASS");
        else
            $display("frustum_box_visibility_test_tb: FAIL");
        $finish;
    end

endmodule
